### rtl/core/wta_pkg.sv
// Shared types, register codes and reset values for the wheel travel accelerator.
`default_nettype none

package wta_pkg;

	// Field widths
	localparam int unsigned POS_W    = 8;
	localparam int unsigned SPEED_W  = 12;
	localparam int unsigned TRAVEL_W = 9;
	localparam int unsigned FLICK_W  = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRISK_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLICK_MINIMUM   = 2'd2;

	// Register reset values
	localparam logic [SPEED_W-1:0] FAST_THRESHOLD_RST  = 12'h2d0;
	localparam logic [SPEED_W-1:0] BRISK_THRESHOLD_RST = 12'h168;
	localparam logic [FLICK_W-1:0] FLICK_MINIMUM_RST   = 8'd10;

	// Speed saturation ceiling
	localparam logic [SPEED_W-1:0] SPEED_MAX = 12'hfff;

	// Configuration register set
	typedef struct packed {
		logic [SPEED_W-1:0] fast_threshold;
		logic [SPEED_W-1:0] brisk_threshold;
		logic [FLICK_W-1:0] flick_minimum;
	} wta_cfg_t;

	// Tracking state carried between frames
	typedef struct packed {
		logic [POS_W-1:0]   last_position;
		logic               last_valid;
		logic [SPEED_W-1:0] speed;
	} wta_state_t;

	// Outcome of one frame: next state and signed travel
	typedef struct packed {
		wta_state_t                  next;
		logic signed [TRAVEL_W-1:0] travel;
	} wta_step_t;

endpackage

`default_nettype wire

### rtl/core/wta_travel.sv
// Combinational travel and speed update for one wheel frame.
`default_nettype none

module wta_travel (
	input  wire logic              contact,
	input  wire logic [7:0]        position,
	input  wire wta_pkg::wta_state_t cur,
	input  wire wta_pkg::wta_cfg_t   cfg,
	output wta_pkg::wta_step_t       step
);
	import wta_pkg::*;

	logic                 pos_gt;
	logic [POS_W-1:0]     diff;
	logic                 far;
	logic [POS_W-2:0]     short_dist;
	logic                 negative;
	logic [POS_W-1:0]     mag;
	logic [SPEED_W:0]     speed_sum;
	logic [SPEED_W-1:0]   speed_acc;
	logic [TRAVEL_W-1:0]  mag_ext;

	// Raw distance and direction
	assign pos_gt = position > cur.last_position;
	assign diff   = pos_gt ? (position - cur.last_position) : (cur.last_position - position);

	// Take the short way round; 255 - d is the bitwise complement, and the direction flips
	assign far        = diff[POS_W-1];
	assign short_dist = far ? ~diff[POS_W-2:0] : diff[POS_W-2:0];
	assign negative   = pos_gt ^ far;

	// Saturating speed accumulation
	assign speed_sum = {1'b0, cur.speed} + {{(SPEED_W-POS_W+2){1'b0}}, short_dist};
	assign speed_acc = speed_sum[SPEED_W] ? SPEED_MAX : speed_sum[SPEED_W-1:0];

	assign mag_ext = {1'b0, mag};

	// Select the acceleration regime and the next state
	always_comb begin
		step.next.last_position = contact ? position : cur.last_position;
		step.next.last_valid    = contact;
		step.next.speed         = cur.speed;
		mag                     = '0;
		step.travel             = '0;
		if (!contact) begin
			step.next.speed = '0;
		end else if (cur.last_valid && (position != cur.last_position)) begin
			if (cur.speed > cfg.fast_threshold) begin
				mag = {short_dist, 1'b0};
			end else if (cur.speed > cfg.brisk_threshold) begin
				mag = {1'b0, short_dist} + {2'b00, short_dist[POS_W-2:1]};
			end else begin
				mag = {1'b0, short_dist};
				if ({1'b0, short_dist} >= cfg.flick_minimum) begin
					step.next.speed = speed_acc;
				end else begin
					step.next.speed = '0;
				end
			end
			step.travel = negative ? $signed(-mag_ext) : $signed(mag_ext);
		end
	end

endmodule

`default_nettype wire

### rtl/core/wheel_travel_accelerator.sv
// Top level: input register, per-frame travel update, output register, config registers.
// Each frame passes through the input register and then the result register. Throughput: one
// frame per cycle while results are taken; the frame state updates as the input register drains.
// A held result stalls the input register, and in_ready drops only when both are full.
// Reset (arst_n low, asynchronous): thresholds return to 720/360/10, speed, last position
// and its valid mark clear, and both pipeline registers empty.
`default_nettype none

module wheel_travel_accelerator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [wta_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [wta_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 wheel_contact,
	input  wire logic [wta_pkg::POS_W-1:0]            wheel_pos,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [wta_pkg::TRAVEL_W-1:0]       travel
);
	import wta_pkg::*;

	wta_cfg_t               cfg_q;
	wta_state_t             state_q;
	logic                   valid_s1;
	logic                   contact_s1;
	logic [POS_W-1:0]       position_s1;
	logic                   adv_s1;
	wta_step_t              step;
	logic signed [TRAVEL_W-1:0] travel_q;
	logic                   out_valid_q;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_threshold  <= FAST_THRESHOLD_RST;
			cfg_q.brisk_threshold <= BRISK_THRESHOLD_RST;
			cfg_q.flick_minimum   <= FLICK_MINIMUM_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FAST_THRESHOLD:  cfg_q.fast_threshold  <= cfg_data;
				REG_BRISK_THRESHOLD: cfg_q.brisk_threshold <= cfg_data;
				REG_FLICK_MINIMUM:   cfg_q.flick_minimum   <= cfg_data[FLICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: drain the input register whenever the result register can take it
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			contact_s1  <= wheel_contact;
			position_s1 <= wheel_pos;
		end
	end

	wta_travel u_travel (
		.contact  (contact_s1),
		.position (position_s1),
		.cur      (state_q),
		.cfg      (cfg_q),
		.step     (step)
	);

	// Advance the frame state with each drained item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= step.next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			travel_q <= step.travel;
		end
	end

	assign out_valid = out_valid_q;
	assign travel    = travel_q;

	// A frame without contact clears the tracking state and reports no travel
	a_no_contact_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !contact_s1) |=>
			(state_q.speed == '0 && !state_q.last_valid && out_valid && travel == '0))
		else $error("no-contact frame did not clear speed and travel");

	// Accelerated travel never leaves -254..254
	a_travel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(travel == 9'sh0ff || travel == 9'sh101 || travel == 9'sh100))
		else $error("travel outside the accelerated range");

	// Input side stalls only when both registers are full and the result is held
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled while pipeline had room");

	// A first contact after a no-contact frame reports no travel
	a_first_contact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && contact_s1 && !state_q.last_valid) |=>
			(travel == '0 && state_q.last_valid && state_q.last_position == $past(position_s1)))
		else $error("first contact produced travel or lost its position");

endmodule

`default_nettype wire
